@@ hdl/izh_pkg.sv @@
// Package for the Izhikevich RK4 neuron pipeline: Q16.16 constants and helpers.
// Used by izh_if, izh_deriv and izhikevich_neuron_rk4_step; depends on nothing.
`default_nettype none
package izh_pkg;
	localparam int unsigned HW = 21;
	localparam int unsigned AW = 17;
	localparam logic [HW-1:0] H_RESET = 21'd65536;
	localparam logic signed [31:0] C004 = 32'sd2621;
	localparam logic signed [31:0] C5 = 32'sd327680;
	localparam logic signed [31:0] C140 = 32'sd9175040;
	localparam logic signed [31:0] C02 = 32'sd13107;
	localparam logic signed [31:0] THRESH = 32'sd1966080;
	localparam logic signed [31:0] VRESET = -32'sd4259840;

	typedef logic signed [31:0] fix_t;

	typedef struct packed {
		fix_t membrane_v;
		fix_t recovery_u;
		fix_t drive_current;
		logic [AW-1:0] recovery_rate_a;
		fix_t reset_jump_d;
		logic last_neuron;
	} in_item_t;

	typedef struct packed {
		fix_t new_v;
		fix_t new_u;
		logic spiked;
		logic last_neuron_out;
	} out_item_t;

	// Saturate a 34-bit signed value to 32 bits.
	function automatic fix_t sat34(input logic signed [33:0] x);
		fix_t r;
		if (x > 34'sd2147483647) r = 32'sh7fffffff;
		else if (x < -34'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

	function automatic fix_t qadd(input fix_t a, input fix_t b);
		logic signed [33:0] s;
		s = 34'(a) + 34'(b);
		return sat34(s);
	endfunction

	function automatic fix_t qsub(input fix_t a, input fix_t b);
		logic signed [33:0] s;
		s = 34'(a) - 34'(b);
		return sat34(s);
	endfunction

	// Arithmetic shift of a product by 16 is floor; then saturate.
	function automatic fix_t qscale(input logic signed [63:0] p);
		logic signed [47:0] q;
		fix_t r;
		q = p[63:16];
		if (q > 48'sd2147483647) r = 32'sh7fffffff;
		else if (q < -48'sd2147483648) r = 32'sh80000000;
		else r = q[31:0];
		return r;
	endfunction

	function automatic fix_t qmul(input fix_t a, input fix_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return qscale(p);
	endfunction
endpackage
`default_nettype wire

@@ hdl/izh_if.sv @@
// Valid/ready channel interface carrying one payload of type T.
// Depends on izh_pkg for payload types.
`default_nettype none
interface izh_if #(parameter type T = izh_pkg::in_item_t) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/izh_deriv.sv @@
// One derivative evaluation (dv/dt, du/dt at zero drive) as a 3-stage pipeline.
// Depends on izh_pkg. Advances when en is high; payload has no reset.
`default_nettype none
module izh_deriv (
	input wire logic clk,
	input wire logic en,
	input wire izh_pkg::fix_t v,
	input wire izh_pkg::fix_t u,
	input wire logic [izh_pkg::AW-1:0] a,
	output izh_pkg::fix_t dv,
	output izh_pkg::fix_t du
);
	izh_pkg::fix_t t_s1, w_s1, uu_s1, a_s1, t_s2, x_s2, a_s2;
	izh_pkg::fix_t dv_s3, du_s3;

	// stage 1: 0.04 v + 5; v, u and a registered alongside
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= izh_pkg::qadd(izh_pkg::qmul(izh_pkg::C004, v), izh_pkg::C5);
			w_s1 <= v;
			uu_s1 <= u;
			a_s1 <= izh_pkg::fix_t'({15'd0, a});
		end
	end

	// stage 2: t*v + 140 - u and 0.2 v - u
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2 <= izh_pkg::qsub(izh_pkg::qadd(izh_pkg::qmul(t_s1, w_s1), izh_pkg::C140),
				uu_s1);
			x_s2 <= izh_pkg::qsub(izh_pkg::qmul(izh_pkg::C02, w_s1), uu_s1);
			a_s2 <= a_s1;
		end
	end

	// stage 3: recovery product
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s3 <= t_s2;
			du_s3 <= izh_pkg::qmul(a_s2, x_s2);
		end
	end

	assign dv = dv_s3;
	assign du = du_s3;
endmodule
`default_nettype wire

@@ hdl/izhikevich_neuron_rk4_step.sv @@
// Top level of the Izhikevich RK4 neuron step: stage pipeline and handshake.
// Depends on izh_pkg, izh_if and izh_deriv.
//
// Usage: one neuron per transfer on the in channel (izh_if sink), one result
// per neuron on the out channel (izh_if source), in order. The step h is set
// through cfg_we/cfg_data while idle; reset loads 1.0 ms.
// Pipeline: four derivative evaluations of three stages each, the first three
// each followed by a one-stage state update, then sum, scale and spike stages.
// The RK sums are started while the last evaluation runs. Throughput is one
// neuron per cycle; the whole pipe advances together, and it freezes while
// the output register holds a result the receiver has not taken, so nothing
// is lost or repeated.
// in.ready is high whenever the output register is empty or being taken.
// Reset clears all valid bits and restores h.
`default_nettype none
module izhikevich_neuron_rk4_step (
	input wire logic clk,
	input wire logic arst_n,
	izh_if.sink in,
	izh_if.source out,
	input wire logic cfg_we,
	input wire logic [izh_pkg::HW-1:0] cfg_data
);
	localparam int unsigned DEPTH = 17;
	typedef struct packed {
		izh_pkg::fix_t v, u, drive, d;
		logic [izh_pkg::AW-1:0] a;
		logic last;
		izh_pkg::fix_t k1, k2, k3, l1, l2, l3;
		izh_pkg::fix_t sk, sl;
	} carry_t;

	logic [izh_pkg::HW-1:0] h_q;
	izh_pkg::fix_t h, hh, h6;
	logic en;
	logic [DEPTH-1:0] vld_q;
	carry_t c_q [DEPTH];
	carry_t c_d [DEPTH];
	izh_pkg::fix_t tv_q [1:3];
	izh_pkg::fix_t tu_q [1:3];
	izh_pkg::fix_t ev_v [4];
	izh_pkg::fix_t ev_u [4];
	logic [izh_pkg::AW-1:0] ev_a [4];
	izh_pkg::fix_t dv [4];
	izh_pkg::fix_t du [4];
	izh_pkg::fix_t sv_s15, su_s15, v_s16, u_s16;
	izh_pkg::out_item_t out_q;
	logic out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) h_q <= izh_pkg::H_RESET;
		else if (cfg_we) h_q <= cfg_data;
	end

	// step fractions; h/6 by reciprocal multiply: floor(x*699051/2^22) exact for x<2^21
	logic [41:0] h6_prod;
	assign h6_prod = 42'(h_q) * 42'd699051;
	assign h = izh_pkg::fix_t'({11'd0, h_q});
	assign hh = izh_pkg::fix_t'({12'd0, h_q[izh_pkg::HW-1:1]});
	assign h6 = izh_pkg::fix_t'({13'd0, h6_prod[40:22]});

	assign en = !out_vld_q || out.ready;
	assign in.ready = en;

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], in.valid};
	end

	// evaluation g starts at stage 4g: raw state first, then each updated state
	genvar g;
	generate
		for (g = 0; g < 4; g++) begin : g_ev
			if (g == 0) begin : g_src
				assign ev_v[g] = in.data.membrane_v;
				assign ev_u[g] = in.data.recovery_u;
				assign ev_a[g] = in.data.recovery_rate_a;
			end else begin : g_src
				assign ev_v[g] = tv_q[g];
				assign ev_u[g] = tu_q[g];
				assign ev_a[g] = c_q[4*g-1].a;
			end
			izh_deriv u_deriv (
				.clk(clk), .en(en), .v(ev_v[g]), .u(ev_u[g]), .a(ev_a[g]),
				.dv(dv[g]), .du(du[g])
			);
		end
	endgenerate

	// next carry: shift, slopes joining after each evaluation, partial RK sums
	always_comb begin
		for (int i = 1; i < DEPTH; i++) c_d[i] = c_q[i-1];
		c_d[0] = '0;
		c_d[0].v = in.data.membrane_v;
		c_d[0].u = in.data.recovery_u;
		c_d[0].drive = in.data.drive_current;
		c_d[0].d = in.data.reset_jump_d;
		c_d[0].a = in.data.recovery_rate_a;
		c_d[0].last = in.data.last_neuron;
		c_d[3].k1 = dv[0];
		c_d[3].l1 = du[0];
		c_d[7].k2 = dv[1];
		c_d[7].l2 = du[1];
		c_d[11].k3 = dv[2];
		c_d[11].l3 = du[2];
		// k1 + k2 + k2, then + k3 + k3, two additions per stage
		c_d[12].sk = izh_pkg::qadd(izh_pkg::qadd(c_q[11].k1, c_q[11].k2), c_q[11].k2);
		c_d[12].sl = izh_pkg::qadd(izh_pkg::qadd(c_q[11].l1, c_q[11].l2), c_q[11].l2);
		c_d[13].sk = izh_pkg::qadd(izh_pkg::qadd(c_q[12].sk, c_q[12].k3), c_q[12].k3);
		c_d[13].sl = izh_pkg::qadd(izh_pkg::qadd(c_q[12].sl, c_q[12].l3), c_q[12].l3);
	end

	// carry pipeline and the update stage after each evaluation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DEPTH; i++) c_q[i] <= c_d[i];
			tv_q[1] <= izh_pkg::qadd(c_q[2].v, izh_pkg::qmul(hh, dv[0]));
			tu_q[1] <= izh_pkg::qadd(c_q[2].u, izh_pkg::qmul(hh, du[0]));
			tv_q[2] <= izh_pkg::qadd(c_q[6].v, izh_pkg::qmul(hh, dv[1]));
			tu_q[2] <= izh_pkg::qadd(c_q[6].u, izh_pkg::qmul(hh, du[1]));
			tv_q[3] <= izh_pkg::qadd(c_q[10].v, izh_pkg::qmul(h, dv[2]));
			tu_q[3] <= izh_pkg::qadd(c_q[10].u, izh_pkg::qmul(h, du[2]));
			// RK sums close with k4
			sv_s15 <= izh_pkg::qadd(c_q[14].sk, dv[3]);
			su_s15 <= izh_pkg::qadd(c_q[14].sl, du[3]);
			// scale and add
			v_s16 <= izh_pkg::qadd(izh_pkg::qadd(c_q[15].v, izh_pkg::qmul(h6, sv_s15)),
				c_q[15].drive);
			u_s16 <= izh_pkg::qadd(c_q[15].u, izh_pkg::qmul(h6, su_s15));
		end
	end

	// output register: spike test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (en) out_vld_q <= vld_q[DEPTH-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.last_neuron_out <= c_q[DEPTH-1].last;
			if (v_s16 >= izh_pkg::THRESH) begin
				out_q.spiked <= 1'b1;
				out_q.new_v <= izh_pkg::VRESET;
				out_q.new_u <= izh_pkg::qadd(u_s16, c_q[DEPTH-1].d);
			end else begin
				out_q.spiked <= 1'b0;
				out_q.new_v <= v_s16;
				out_q.new_u <= u_s16;
			end
		end
	end

	assign out.valid = out_vld_q;
	assign out.data = out_q;

	// a held result stays put while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out.ready |=> out_vld_q && $stable(out_q))
		else $error("result changed under stall");
	// pipe freezes under stall
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipe moved under stall");
	// spike always carries the reset potential
	a_spk: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.spiked |-> out_q.new_v == izh_pkg::VRESET)
		else $error("spike without reset value");
endmodule
`default_nettype wire

@@ verif/izh_step_checker.sv @@
// Checker for the Izhikevich RK4 neuron step: watches the in, out and config ports,
// predicts each result in Q16.16 and compares it with what the block hands out.
// Depends on izh_pkg for the channel payload types and the reset value of h.
module izh_step_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input izh_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input izh_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [izh_pkg::HW-1:0] cfg_data,
	output int pending,
	output int fails
);
	localparam int FX_MAX = 32'h7fffffff;
	localparam int FX_MIN = 32'h80000000;

	logic [izh_pkg::HW-1:0] step_h;
	izh_pkg::out_item_t neuron_q[$];

	// clamp a wide value to the Q16.16 word range
	function automatic int fx_clamp(input longint x);
		if (x > longint'(FX_MAX)) return FX_MAX;
		if (x < longint'(FX_MIN)) return FX_MIN;
		return int'(x);
	endfunction

	function automatic int fx_plus(input int x, input int y);
		return fx_clamp(longint'(x) + longint'(y));
	endfunction

	function automatic int fx_minus(input int x, input int y);
		return fx_clamp(longint'(x) - longint'(y));
	endfunction

	// exact product, floor shift by 16
	function automatic int fx_times(input int x, input int y);
		longint p;
		p = longint'(x) * longint'(y);
		return fx_clamp(p >>> 16);
	endfunction

	function automatic int v_slope(input int v, input int u);
		int t;
		t = fx_plus(fx_times(izh_pkg::C004, v), izh_pkg::C5);
		t = fx_plus(fx_times(t, v), izh_pkg::C140);
		return fx_minus(t, u);
	endfunction

	function automatic int u_slope(input int v, input int u, input int a);
		return fx_times(a, fx_minus(fx_times(izh_pkg::C02, v), u));
	endfunction

	function automatic int rk_weighted(input int s1, input int s2, input int s3, input int s4);
		int s;
		s = fx_plus(s1, s2);
		s = fx_plus(s, s2);
		s = fx_plus(s, s3);
		s = fx_plus(s, s3);
		return fx_plus(s, s4);
	endfunction

	// one RK4 step at zero drive, then drive, threshold and reset
	function automatic izh_pkg::out_item_t neuron_advance(input izh_pkg::in_item_t n,
		input logic [izh_pkg::HW-1:0] hcfg);
		izh_pkg::out_item_t r;
		int v, u, a, h, hh, h6;
		int k1, k2, k3, k4, l1, l2, l3, l4, tv, tu;
		v = n.membrane_v;
		u = n.recovery_u;
		a = int'({15'd0, n.recovery_rate_a});
		h = int'({11'd0, hcfg});
		hh = h / 2;
		h6 = h / 6;
		k1 = v_slope(v, u);
		l1 = u_slope(v, u, a);
		tv = fx_plus(v, fx_times(hh, k1));
		tu = fx_plus(u, fx_times(hh, l1));
		k2 = v_slope(tv, tu);
		l2 = u_slope(tv, tu, a);
		tv = fx_plus(v, fx_times(hh, k2));
		tu = fx_plus(u, fx_times(hh, l2));
		k3 = v_slope(tv, tu);
		l3 = u_slope(tv, tu, a);
		tv = fx_plus(v, fx_times(h, k3));
		tu = fx_plus(u, fx_times(h, l3));
		k4 = v_slope(tv, tu);
		l4 = u_slope(tv, tu, a);
		v = fx_plus(fx_plus(v, fx_times(h6, rk_weighted(k1, k2, k3, k4))), n.drive_current);
		u = fx_plus(u, fx_times(h6, rk_weighted(l1, l2, l3, l4)));
		r.spiked = 1'b0;
		if (v >= izh_pkg::THRESH) begin
			r.spiked = 1'b1;
			v = izh_pkg::VRESET;
			u = fx_plus(u, n.reset_jump_d);
		end
		r.new_v = v;
		r.new_u = u;
		r.last_neuron_out = n.last_neuron;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint expd, input longint got);
		$display("mismatch %s: expected %0d got %0d", what, expd, got);
		fails++;
	endtask

	initial fails = 0;
	assign pending = neuron_q.size();

	// track h, queue predictions on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		izh_pkg::out_item_t e;
		if (!arst_n) begin
			step_h <= izh_pkg::H_RESET;
		end else begin
			if (cfg_we)
				step_h <= cfg_data;
			if (in_valid && in_ready)
				neuron_q.push_back(neuron_advance(in_data, step_h));
			if (out_valid && out_ready) begin
				if (neuron_q.size() == 0) begin
					report_mismatch("unexpected result, queue depth", 0, 1);
				end else begin
					e = neuron_q.pop_front();
					if (out_data.new_v !== e.new_v)
						report_mismatch("new_v", e.new_v, out_data.new_v);
					if (out_data.new_u !== e.new_u)
						report_mismatch("new_u", e.new_u, out_data.new_u);
					if (out_data.spiked !== e.spiked)
						report_mismatch("spiked", e.spiked, out_data.spiked);
					if (out_data.last_neuron_out !== e.last_neuron_out)
						report_mismatch("last_neuron_out", e.last_neuron_out,
							out_data.last_neuron_out);
				end
			end
		end
	end
endmodule

@@ verif/izhikevich_neuron_rk4_step_test.sv @@
// Testbench top for izhikevich_neuron_rk4_step: directed and random neurons under
// several step sizes, random stalls on both channels; depends on izh_pkg, izh_if, checker.
module izhikevich_neuron_rk4_step_test;
	localparam int PIPE_WAIT = 30;
	localparam int WATCH_LIMIT = 4000;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [izh_pkg::HW-1:0] cfg_data = '0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	logic quiet = 1'b0;
	int hold_left = 0;
	int gap_left = 0;
	int idle_cycles = 0;
	int pending, fails;

	izh_if #(.T(izh_pkg::in_item_t)) in_ch ();
	izh_if #(.T(izh_pkg::out_item_t)) out_ch ();

	izhikevich_neuron_rk4_step dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	izh_step_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.pending(pending),
		.fails(fails)
	);

	always #10 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	// receiver: one long hold on request, always ready when quiet, otherwise random stall bursts
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= LONG_HOLD;
			hold_done <= 1'b1;
			out_ch.ready <= 1'b0;
		end else if (quiet) begin
			out_ch.ready <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			gap_left <= $urandom_range(0, 9);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic izh_pkg::in_item_t mk_neuron(input int v, input int u, input int drive,
		input int a, input int d, input bit last);
		izh_pkg::in_item_t n;
		n.membrane_v = v;
		n.recovery_u = u;
		n.drive_current = drive;
		n.recovery_rate_a = a[izh_pkg::AW-1:0];
		n.reset_jump_d = d;
		n.last_neuron = last;
		return n;
	endfunction

	// mostly plausible neurons, some raw noise over the full field widths
	function automatic izh_pkg::in_item_t rand_neuron();
		if ($urandom_range(0, 3) == 0)
			return mk_neuron(int'($urandom), int'($urandom), int'($urandom),
				int'($urandom_range(0, 131071)), int'($urandom),
				1'($urandom_range(0, 1)));
		return mk_neuron(-80 * 65536 + int'($urandom_range(0, 120 * 65536)),
			-20 * 65536 + int'($urandom_range(0, 40 * 65536)),
			-5 * 65536 + int'($urandom_range(0, 40 * 65536)),
			int'($urandom_range(0, 13107)), int'($urandom_range(0, 10 * 65536)),
			$urandom_range(0, 15) == 0);
	endfunction

	// offer one neuron, sometimes after a random gap (never when quiet), and wait for its transfer
	task automatic send_neuron(input izh_pkg::in_item_t n);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= n;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// drop valid and wait for every result, plus the pipe latency
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic write_step(input logic [izh_pkg::HW-1:0] h);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [izh_pkg::HW-1:0] steps[7];
		int unsigned pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed neurons at the default 1 ms step
		send_neuron(mk_neuron(-65 * 65536, -13 * 65536, 0, 1311, 8 * 65536, 1'b0));
		send_neuron(mk_neuron(izh_pkg::THRESH, 0, 0, 1311, 8 * 65536, 1'b1));
		send_neuron(mk_neuron(izh_pkg::THRESH - 1, 0, 0, 1311, 8 * 65536, 1'b0));
		send_neuron(mk_neuron(-65 * 65536, 0, 95 * 65536, 1311, 2 * 65536, 1'b0));
		send_neuron(mk_neuron(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65536,
			32'h7fffffff, 1'b1));
		send_neuron(mk_neuron(32'h80000000, 32'h80000000, 32'h80000000, 0,
			32'h80000000, 1'b0));
		send_neuron(mk_neuron(32'h7fffffff, 32'h80000000, 0, 131071, 32'h80000000, 1'b1));
		send_neuron(mk_neuron(32'h80000000, 32'h7fffffff, 32'h7fffffff, 131071,
			32'h7fffffff, 1'b0));
		send_neuron(mk_neuron(0, 0, 0, 0, 0, 1'b0));
		send_neuron(mk_neuron(-1, -1, -1, 1, -1, 1'b1));
		send_neuron(mk_neuron(40 * 65536, 5 * 65536, 0, 65536, 32'h7fffffff, 1'b0));
		send_neuron(mk_neuron(20 * 65536, -30 * 65536, 10 * 65536, 6554, 32'h80000000, 1'b0));
		send_neuron(mk_neuron(-70 * 65536, -14 * 65536, 32'h80000000, 13107, 65536, 1'b1));
		send_neuron(mk_neuron(-65 * 65536, -13 * 65536, 32'h7fffffff, 1311, 8 * 65536, 1'b0));
		for (int i = 0; i < 6; i++)
			send_neuron(rand_neuron());

		// random phases across step sizes, extremes included
		steps = '{21'd1, 21'h1fffff, 21'd0, 21'd1048576, 21'd0, 21'd32768, izh_pkg::H_RESET};
		pick = $urandom_range(1, 1048576);
		steps[4] = pick[izh_pkg::HW-1:0];
		for (int ph = 0; ph < 7; ph++) begin
			write_step(steps[ph]);
			if (ph == 6)
				quiet = 1'b1;
			for (int i = 0; i < 262; i++) begin
				if (ph == 1 && i == 100)
					hold_req = 1'b1;
				send_neuron(rand_neuron());
			end
		end

		drain();
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
